/* hw/rtl/mvw_pkg.sv */
// ----------------------------------------------------------------------------
// mvw_pkg
// Shared constants, codes and types of the mesh vertex weld block.
// ----------------------------------------------------------------------------
`default_nettype none

package mvw_pkg;

  localparam int MaxVertices = 1024;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = IdxW + 1;
  localparam int FieldIdxW   = 10;
  localparam int CoordW      = 32;
  localparam int NrmW        = 16;
  localparam int ThreshW     = 40;

  localparam logic [ThreshW-1:0] ThreshReset = 40'd110;

  typedef enum logic [1:0] {
    REQ_NEW    = 2'd0,
    REQ_VERTEX = 2'd1,
    REQ_TRI    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_TRI    = 2'd1,
    KIND_OVF    = 2'd2
  } kind_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NrmW-1:0]   nrm_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t pa;
    vec_t pb;
    vec_t pc;
    nrm_t gx;
    nrm_t gy;
    nrm_t gz;
  } norm_in_t;

  typedef struct packed {
    nrm_t nx;
    nrm_t ny;
    nrm_t nz;
    logic swap;
  } norm_out_t;

  typedef struct packed {
    logic [1:0]           out_kind;
    coord_t               out_x;
    coord_t               out_y;
    coord_t               out_z;
    logic [FieldIdxW-1:0] out_a;
    logic [FieldIdxW-1:0] out_b;
    logic [FieldIdxW-1:0] out_c;
    nrm_t                 out_nx;
    nrm_t                 out_ny;
    nrm_t                 out_nz;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/mvw_ifs.sv */
// ----------------------------------------------------------------------------
// mvw channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvw_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic [9:0]        corner_a;
  logic [9:0]        corner_b;
  logic [9:0]        corner_c;
  logic signed [15:0] given_nx;
  logic signed [15:0] given_ny;
  logic signed [15:0] given_nz;

  modport source (output valid, req_type, vertex_x, vertex_y, vertex_z,
                  corner_a, corner_b, corner_c, given_nx, given_ny, given_nz,
                  input ready);
  modport sink (input valid, req_type, vertex_x, vertex_y, vertex_z,
                corner_a, corner_b, corner_c, given_nx, given_ny, given_nz,
                output ready);
endinterface

interface mvw_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [9:0]        out_a;
  logic [9:0]        out_b;
  logic [9:0]        out_c;
  logic signed [15:0] out_nx;
  logic signed [15:0] out_ny;
  logic signed [15:0] out_nz;

  modport source (output valid, out_kind, out_x, out_y, out_z, out_a, out_b, out_c,
                  out_nx, out_ny, out_nz, input ready);
  modport sink (input valid, out_kind, out_x, out_y, out_z, out_a, out_b, out_c,
                out_nx, out_ny, out_nz, output ready);
endinterface

interface mvw_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] weld_threshold_sq;

  modport source (output valid, weld_threshold_sq, input ready);
  modport sink (input valid, weld_threshold_sq, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mvw_norm.sv */
// ----------------------------------------------------------------------------
// mvw_norm
// Face normal unit: cross product, normalization, integer square root,
// winding test and per-component division; products share one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mvw_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  mvw_pkg::norm_in_t    in_i,
  output logic                 done_o,
  output mvw_pkg::norm_out_t   out_o
);

  typedef enum logic [9:0] {
    N_IDLE  = 10'b0000000001,
    N_DIFF  = 10'b0000000010,
    N_CROSS = 10'b0000000100,
    N_ABS   = 10'b0000001000,
    N_NORM  = 10'b0000010000,
    N_SQR   = 10'b0000100000,
    N_SQRT  = 10'b0001000000,
    N_DOT   = 10'b0010000000,
    N_DIV   = 10'b0100000000,
    N_DONE  = 10'b1000000000
  } nstate_e;

  nstate_e state_q, state_d;
  mvw_pkg::norm_in_t in_q;

  logic signed [31:0] d1_q [3];
  logic signed [31:0] d2_q [3];
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic               big;

  logic [2:0]         step_q;
  logic [2:0]         step_m1;
  logic [1:0]         ksel;
  logic signed [31:0] mul_a, mul_b, mm;
  logic signed [63:0] prod_q;
  logic signed [63:0] c_q [3];
  logic [62:0]        m_q [3];
  logic [62:0]        mx;

  logic [63:0]        sq_n_q, sq_r_q, sq_b_q, sq_rb;
  logic signed [63:0] dot_q;
  logic [31:0]        len;

  logic [1:0]         dk_q, ld_sel;
  logic [4:0]         db_q;
  logic [49:0]        rem_q, rem_init, dsh;
  logic               take;
  logic [16:0]        qacc_q, qnext;
  logic [14:0]        qsat;
  logic [14:0]        q_q [3];
  logic [15:0]        qs [3];
  logic               neg [3];

  function automatic logic is_big(input logic signed [32:0] e);
    return (!e[32] && e[31]) || (e[32] && (!e[31] || e[30:0] == '0));
  endfunction

  // Corner differences, exact in 33 bits
  always_comb begin
    e1[0] = $signed({in_q.pb.x[31], in_q.pb.x}) - $signed({in_q.pa.x[31], in_q.pa.x});
    e1[1] = $signed({in_q.pb.y[31], in_q.pb.y}) - $signed({in_q.pa.y[31], in_q.pa.y});
    e1[2] = $signed({in_q.pb.z[31], in_q.pb.z}) - $signed({in_q.pa.z[31], in_q.pa.z});
    e2[0] = $signed({in_q.pc.x[31], in_q.pc.x}) - $signed({in_q.pa.x[31], in_q.pa.x});
    e2[1] = $signed({in_q.pc.y[31], in_q.pc.y}) - $signed({in_q.pa.y[31], in_q.pa.y});
    e2[2] = $signed({in_q.pc.z[31], in_q.pc.z}) - $signed({in_q.pa.z[31], in_q.pa.z});
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      big = big | is_big(e1[k]) | is_big(e2[k]);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    ksel  = (step_q == 3'd3) ? 2'd2 : step_q[1:0];
    mm    = $signed({1'b0, m_q[ksel][30:0]});
    mul_a = '0;
    mul_b = '0;
    if (state_q == N_CROSS) begin
      case (step_q)
        3'd0: begin mul_a = d1_q[1]; mul_b = d2_q[2]; end
        3'd1: begin mul_a = d1_q[2]; mul_b = d2_q[1]; end
        3'd2: begin mul_a = d1_q[2]; mul_b = d2_q[0]; end
        3'd3: begin mul_a = d1_q[0]; mul_b = d2_q[2]; end
        3'd4: begin mul_a = d1_q[0]; mul_b = d2_q[1]; end
        3'd5: begin mul_a = d1_q[1]; mul_b = d2_q[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == N_SQR) begin
      mul_a = mm;
      mul_b = mm;
    end else if (state_q == N_DOT) begin
      mul_a = c_q[ksel][63] ? -mm : mm;
      case (ksel)
        2'd0:    mul_b = 32'(in_q.gx);
        2'd1:    mul_b = 32'(in_q.gy);
        default: mul_b = 32'(in_q.gz);
      endcase
    end
  end

  always_comb begin
    step_m1 = step_q - 3'd1;
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    sq_rb    = sq_r_q + sq_b_q;
    len      = sq_r_q[31:0];
    ld_sel   = (state_q == N_DIV) ? ((dk_q == 2'd2) ? 2'd2 : dk_q + 2'd1) : 2'd0;
    rem_init = {3'b0, m_q[ld_sel][30:0], 16'b0} + {18'b0, len};
    dsh      = {17'b0, len, 1'b0} << db_q;
    take     = rem_q >= dsh;
    qnext    = qacc_q | (take ? (17'd1 << db_q) : 17'd0);
    qsat     = (qnext > 17'd32767) ? 15'h7fff : qnext[14:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (start_i) state_d = N_DIFF;
      N_DIFF:  state_d = N_CROSS;
      N_CROSS: if (step_q == 3'd6) state_d = N_ABS;
      N_ABS:   state_d = N_NORM;
      N_NORM: begin
        if (mx == '0) begin
          state_d = N_DONE;
        end else if (mx[62:31] == '0 && mx[30]) begin
          state_d = N_SQR;
        end
      end
      N_SQR:   if (step_q == 3'd3) state_d = N_SQRT;
      N_SQRT:  if (sq_b_q == 64'd1) state_d = N_DOT;
      N_DOT:   if (step_q == 3'd3) state_d = N_DIV;
      N_DIV:   if (dk_q == 2'd2 && db_q == 5'd0) state_d = N_DONE;
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      N_IDLE: begin
        if (start_i) in_q <= in_i;
      end
      N_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          d1_q[k] <= big ? {e1[k][32], e1[k][32:2]} : e1[k][31:0];
          d2_q[k] <= big ? {e2[k][32], e2[k][32:2]} : e2[k][31:0];
          c_q[k]  <= '0;
        end
        step_q <= '0;
      end
      N_CROSS: begin
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) begin
          c_q[step_m1[2:1]] <= step_m1[0] ? c_q[step_m1[2:1]] - prod_q
                                           : c_q[step_m1[2:1]] + prod_q;
        end
      end
      N_ABS: begin
        for (int k = 0; k < 3; k++) begin
          m_q[k] <= c_q[k][63] ? 63'(-c_q[k]) : c_q[k][62:0];
          q_q[k] <= '0;
        end
        dot_q <= '0;
      end
      N_NORM: begin
        if (mx[62:31] != '0) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
        end else if (!mx[30]) begin
          for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
        end
        step_q <= '0;
        sq_n_q <= '0;
        sq_r_q <= '0;
        sq_b_q <= 64'd1 << 62;
      end
      N_SQR: begin
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) sq_n_q <= sq_n_q + $unsigned(prod_q);
      end
      N_SQRT: begin
        if (sq_n_q >= sq_rb) begin
          sq_n_q <= sq_n_q - sq_rb;
          sq_r_q <= (sq_r_q >> 1) + sq_b_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_b_q <= sq_b_q >> 2;
        step_q <= '0;
      end
      N_DOT: begin
        step_q <= step_q + 3'd1;
        if (step_q != 3'd0) dot_q <= dot_q + prod_q;
        dk_q   <= '0;
        db_q   <= 5'd16;
        qacc_q <= '0;
        rem_q  <= rem_init;
      end
      N_DIV: begin
        if (db_q == 5'd0) begin
          q_q[dk_q] <= qsat;
          dk_q      <= ld_sel;
          db_q      <= 5'd16;
          qacc_q    <= '0;
          rem_q     <= rem_init;
        end else begin
          if (take) rem_q <= rem_q - dsh;
          qacc_q <= qnext;
          db_q   <= db_q - 5'd1;
        end
      end
      N_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = c_q[k][63] ^ dot_q[63];
      qs[k]  = {1'b0, q_q[k]};
    end
    out_o.nx   = neg[0] ? $signed(16'd0 - qs[0]) : $signed(qs[0]);
    out_o.ny   = neg[1] ? $signed(16'd0 - qs[1]) : $signed(qs[1]);
    out_o.nz   = neg[2] ? $signed(16'd0 - qs[2]) : $signed(qs[2]);
    out_o.swap = dot_q[63];
  end

  assign done_o = (state_q == N_DONE);

endmodule

`default_nettype wire

/* hw/rtl/mesh_vertex_weld_and_normals.sv */
// Vertex: scan of the stored representatives, then the weld map write, then an emit when it is new;
// the representative scan reads one memory entry a cycle.
// Triangle: time is dominated by the normal unit (square root and division loops).
// New mesh and ignored items are handled in the idle state. One item is processed at a time.
// Reset clears counters and control, threshold returns to 110; memories are not
// cleared and need no clearing pass. The result register frees the input side.
// ----------------------------------------------------------------------------
// mesh_vertex_weld_and_normals
// Welds vertices against stored representatives, emitting each new one (or an overflow result),
// and emits remapped triangles with recomputed unit face normals.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_weld_and_normals (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvw_req_if.sink   req,
  mvw_rsp_if.source rsp,
  mvw_cfg_if.sink   cfg
);

  localparam int IdxW = mvw_pkg::IdxW;
  localparam int CntW = mvw_pkg::CntW;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_VSCAN  = 8'b00000010,
    S_VWR    = 8'b00000100,
    S_TMAP   = 8'b00001000,
    S_TREP   = 8'b00010000,
    S_TSTART = 8'b00100000,
    S_TNORM  = 8'b01000000,
    S_EMIT   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  mvw_pkg::vec_t           rep_mem  [mvw_pkg::MaxVertices];
  logic [IdxW-1:0]         wmap_mem [mvw_pkg::MaxVertices];
  mvw_pkg::vec_t           rep_rd_q, rep_wdata;
  logic [IdxW-1:0]         wmap_rd_q, wmap_wdata;
  logic [IdxW-1:0]         rep_raddr, rep_waddr, wmap_raddr, wmap_waddr;
  logic                    rep_we, wmap_we;

  logic [mvw_pkg::ThreshW-1:0] thresh_q;
  logic [CntW-1:0]         rep_cnt_q, rep_cnt_d, ld_cnt_q, ld_cnt_d, iss_q, iss_d;
  logic                    found_q, found_d;
  logic [IdxW-1:0]         hit_q, hit_d;
  logic [1:0]              tstep_q, tstep_d, tsel, tprev;

  mvw_pkg::vec_t           v_q;
  logic [9:0]              cor_q [3];
  mvw_pkg::nrm_t           g_q [3];

  logic                    issue, va_q, vb_q, vc_q;
  logic [IdxW-1:0]         tag_a_q, tag_b_q, tag_c_q;
  logic signed [32:0]      ed [3];
  logic [32:0]             ea [3];
  logic [19:0]             ab_q [3];
  logic                    near_b_q, near_c_q;
  logic [39:0]             sq_c_q [3];
  logic [41:0]             dsq;
  logic                    hit_now;

  logic                    ok_q;
  logic [IdxW-1:0]         idx_q [3];
  mvw_pkg::vec_t           pos_q [3];

  logic                    norm_start, norm_done;
  mvw_pkg::norm_in_t       norm_in;
  mvw_pkg::norm_out_t      norm_out;

  mvw_pkg::rsp_t           pend_q, pend_d, rsp_q;
  logic                    rsp_vld_q, rsp_vld_d, rsp_load;
  logic                    accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign cfg.ready = 1'b1;

  assign tsel  = (tstep_q == 2'd3) ? 2'd2 : tstep_q;
  assign tprev = tstep_q - 2'd1;
  assign issue = (state_q == S_VSCAN) && (iss_q < rep_cnt_q);

  // Scan datapath: difference, square, compare
  always_comb begin
    ed[0] = $signed({v_q.x[31], v_q.x}) - $signed({rep_rd_q.x[31], rep_rd_q.x});
    ed[1] = $signed({v_q.y[31], v_q.y}) - $signed({rep_rd_q.y[31], rep_rd_q.y});
    ed[2] = $signed({v_q.z[31], v_q.z}) - $signed({rep_rd_q.z[31], rep_rd_q.z});
    for (int k = 0; k < 3; k++) begin
      ea[k] = ed[k][32] ? 33'(-ed[k]) : ed[k];
    end
    dsq     = {2'b0, sq_c_q[0]} + {2'b0, sq_c_q[1]} + {2'b0, sq_c_q[2]};
    hit_now = vc_q && near_c_q && (dsq <= {2'b0, thresh_q});
  end

  always_comb begin
    norm_in.pa = pos_q[0];
    norm_in.pb = pos_q[1];
    norm_in.pc = pos_q[2];
    norm_in.gx = g_q[0];
    norm_in.gy = g_q[1];
    norm_in.gz = g_q[2];
  end

  mvw_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .in_i   (norm_in),
    .done_o (norm_done),
    .out_o  (norm_out)
  );

  always_comb begin
    state_d    = state_q;
    rep_cnt_d  = rep_cnt_q;
    ld_cnt_d   = ld_cnt_q;
    iss_d      = iss_q;
    found_d    = found_q;
    hit_d      = hit_q;
    tstep_d    = tstep_q;
    pend_d     = pend_q;
    rep_we     = 1'b0;
    wmap_we    = 1'b0;
    rep_waddr  = rep_cnt_q[IdxW-1:0];
    rep_wdata  = v_q;
    wmap_waddr = ld_cnt_q[IdxW-1:0];
    wmap_wdata = rep_cnt_q[IdxW-1:0];
    rep_raddr  = (state_q == S_VSCAN) ? iss_q[IdxW-1:0] : idx_q[tsel];
    wmap_raddr = IdxW'(cor_q[tsel]);
    norm_start = 1'b0;
    rsp_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mvw_pkg::req_e'(req.req_type))
            mvw_pkg::REQ_NEW: begin
              rep_cnt_d = '0;
              ld_cnt_d  = '0;
            end
            mvw_pkg::REQ_VERTEX: begin
              if (ld_cnt_q >= CntW'(mvw_pkg::MaxVertices)) begin
                pend_d          = '0;
                pend_d.out_kind = mvw_pkg::KIND_OVF;
                state_d         = S_EMIT;
              end else begin
                iss_d   = '0;
                found_d = 1'b0;
                state_d = S_VSCAN;
              end
            end
            mvw_pkg::REQ_TRI: begin
              tstep_d = '0;
              state_d = S_TMAP;
            end
            default: begin
            end
          endcase
        end
      end
      S_VSCAN: begin
        if (issue) iss_d = iss_q + 1'b1;
        if (hit_now) begin
          found_d = 1'b1;
          hit_d   = tag_c_q;
        end
        if (!issue && !va_q && !vb_q && !vc_q) state_d = S_VWR;
      end
      S_VWR: begin
        wmap_we  = 1'b1;
        ld_cnt_d = ld_cnt_q + 1'b1;
        if (found_q) begin
          wmap_wdata = hit_q;
          state_d    = S_IDLE;
        end else begin
          rep_we          = 1'b1;
          rep_cnt_d       = rep_cnt_q + 1'b1;
          pend_d          = '0;
          pend_d.out_kind = mvw_pkg::KIND_VERTEX;
          pend_d.out_x    = v_q.x;
          pend_d.out_y    = v_q.y;
          pend_d.out_z    = v_q.z;
          pend_d.out_a    = mvw_pkg::FieldIdxW'(rep_cnt_q);
          state_d         = S_EMIT;
        end
      end
      S_TMAP: begin
        tstep_d = tstep_q + 2'd1;
        if (tstep_q == 2'd3) state_d = S_TREP;
      end
      S_TREP: begin
        tstep_d = tstep_q + 2'd1;
        if (tstep_q == 2'd3) state_d = S_TSTART;
      end
      S_TSTART: begin
        norm_start = 1'b1;
        state_d    = S_TNORM;
      end
      S_TNORM: begin
        if (norm_done) begin
          pend_d.out_kind = mvw_pkg::KIND_TRI;
          pend_d.out_x    = '0;
          pend_d.out_y    = '0;
          pend_d.out_z    = '0;
          pend_d.out_a    = mvw_pkg::FieldIdxW'(idx_q[0]);
          pend_d.out_b    = mvw_pkg::FieldIdxW'(norm_out.swap ? idx_q[2] : idx_q[1]);
          pend_d.out_c    = mvw_pkg::FieldIdxW'(norm_out.swap ? idx_q[1] : idx_q[2]);
          pend_d.out_nx   = norm_out.nx;
          pend_d.out_ny   = norm_out.ny;
          pend_d.out_nz   = norm_out.nz;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rsp_vld_q || rsp.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    rsp_vld_d = rsp_load ? 1'b1 : (rsp_vld_q && !rsp.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      thresh_q  <= mvw_pkg::ThreshReset;
      rep_cnt_q <= '0;
      ld_cnt_q  <= '0;
      iss_q     <= '0;
      found_q   <= 1'b0;
      tstep_q   <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg.valid) thresh_q <= cfg.weld_threshold_sq;
      rep_cnt_q <= rep_cnt_d;
      ld_cnt_q  <= ld_cnt_d;
      iss_q     <= iss_d;
      found_q   <= found_d;
      tstep_q   <= tstep_d;
      va_q      <= issue;
      vb_q      <= va_q;
      vc_q      <= vb_q;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // Memories, one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (rep_we) rep_mem[rep_waddr] <= rep_wdata;
    rep_rd_q <= rep_mem[rep_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wmap_we) wmap_mem[wmap_waddr] <= wmap_wdata;
    wmap_rd_q <= wmap_mem[wmap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q.x    <= req.vertex_x;
      v_q.y    <= req.vertex_y;
      v_q.z    <= req.vertex_z;
      cor_q[0] <= req.corner_a;
      cor_q[1] <= req.corner_b;
      cor_q[2] <= req.corner_c;
      g_q[0]   <= req.given_nx;
      g_q[1]   <= req.given_ny;
      g_q[2]   <= req.given_nz;
    end
    hit_q    <= hit_d;
    tag_a_q  <= iss_q[IdxW-1:0];
    tag_b_q  <= tag_a_q;
    tag_c_q  <= tag_b_q;
    near_b_q <= (ea[0][32:20] == '0) && (ea[1][32:20] == '0) && (ea[2][32:20] == '0);
    near_c_q <= near_b_q;
    for (int k = 0; k < 3; k++) begin
      ab_q[k]   <= ea[k][19:0];
      sq_c_q[k] <= {20'b0, ab_q[k]} * {20'b0, ab_q[k]};
    end
    if (state_q == S_TMAP) begin
      ok_q <= 32'(cor_q[tsel]) < 32'(ld_cnt_q);
      if (tstep_q != 2'd0) idx_q[tprev] <= ok_q ? wmap_rd_q : '0;
    end else begin
      ok_q <= CntW'(idx_q[tsel]) < rep_cnt_q;
    end
    if (state_q == S_TREP && tstep_q != 2'd0) begin
      pos_q[tprev] <= ok_q ? rep_rd_q : '0;
    end
    pend_q <= pend_d;
    if (rsp_load) rsp_q <= pend_q;
  end

  assign rsp.valid    = rsp_vld_q;
  assign rsp.out_kind = rsp_q.out_kind;
  assign rsp.out_x    = rsp_q.out_x;
  assign rsp.out_y    = rsp_q.out_y;
  assign rsp.out_z    = rsp_q.out_z;
  assign rsp.out_a    = rsp_q.out_a;
  assign rsp.out_b    = rsp_q.out_b;
  assign rsp.out_c    = rsp_q.out_c;
  assign rsp.out_nx   = rsp_q.out_nx;
  assign rsp.out_ny   = rsp_q.out_ny;
  assign rsp.out_nz   = rsp_q.out_nz;

  a_rep_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q <= ld_cnt_q)
    else $error("representative count exceeds loaded count");

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_cnt_q <= CntW'(mvw_pkg::MaxVertices))
    else $error("loaded count beyond capacity");

  a_norm_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> (state_q == S_TNORM))
    else $error("normal unit finished outside triangle wait");

  a_vwr_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VWR) |=> (ld_cnt_q == CntW'($past(ld_cnt_q) + 1'b1)))
    else $error("vertex write did not advance loaded count");

endmodule

`default_nettype wire
